/* rtl/brbc_pkg.sv */
// ----------------------------------------------------------------------------
// brbc_pkg
// Types, constants and helper functions for the byte ring buffer with CRC.
// ----------------------------------------------------------------------------
package brbc_pkg;

  // Byte store geometry
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SIZE_W   = ADDR_W + 1;
  localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(DEPTH - 1);
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(DEPTH);

  // CRC-16/CCITT fold terms, one per bit of the table index
  localparam logic [15:0] CRC_TERMS [8] = '{
    16'h1021, 16'h2042, 16'h4084, 16'h8108,
    16'h1231, 16'h2462, 16'h48C4, 16'h9188
  };
  localparam logic [7:0] BYTE_INVALID = 8'hFF;

  typedef enum logic [2:0] {
    CMD_PUT8  = 3'd0,
    CMD_PUT16 = 3'd1,
    CMD_POP8  = 3'd2,
    CMD_POP16 = 3'd3,
    CMD_POP32 = 3'd4,
    CMD_PEEK  = 3'd5,
    CMD_CRC   = 3'd6,
    CMD_CLEAR = 3'd7
  } brbc_cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_CLEAR,
    ST_DONE
  } brbc_state_t;

  // Clamp a written ring size into 2..DEPTH
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = v;
    if (s < SIZE_MIN) s = SIZE_MIN;
    if (s > SIZE_MAX) s = SIZE_MAX;
    return s;
  endfunction

  // Step an index, wrapping at the ring size
  function automatic logic [ADDR_W-1:0] ring_adv(input logic [ADDR_W-1:0] idx,
                                                 input logic [SIZE_W-1:0] ring);
    logic [SIZE_W-1:0] n;
    n = {1'b0, idx} + SIZE_W'(1);
    if (n >= ring) n = '0;
    return n[ADDR_W-1:0];
  endfunction

  // Bytes between read and write index
  function automatic logic [ADDR_W-1:0] ring_fill(input logic [ADDR_W-1:0] w,
                                                  input logic [ADDR_W-1:0] r,
                                                  input logic [SIZE_W-1:0] ring);
    logic [SIZE_W-1:0] t;
    if (w < r) t = ring + {1'b0, w} - {1'b0, r};
    else       t = {1'b0, w} - {1'b0, r};
    return t[ADDR_W-1:0];
  endfunction

  // Fold one byte into the CRC, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  idx;
    logic [15:0] tab;
    idx = b ^ crc[15:8];
    tab = '0;
    for (int i = 0; i < 8; i++) begin
      if (idx[i]) tab = tab ^ CRC_TERMS[i];
    end
    return {crc[7:0] ^ tab[15:8], tab[7:0]};
  endfunction

endpackage

/* rtl/byte_ring_buffer_with_crc.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_crc
// Byte ring buffer over a single byte-wide synchronous store, with put, pop,
// peek, clear and a CRC-16/CCITT walk over a window of the ring.
// ----------------------------------------------------------------------------
// The store takes one access per cycle, and commands run one at a time:
// busy is high from accept until the result strobe, and the next command
// may be accepted in the cycle of the strobe.
// After reset a zeroing pass over every byte of the store runs with busy
// high; config writes are taken during it. The receiver cannot stall the
// result strobe.
module byte_ring_buffer_with_crc
  import brbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_cmd,
  input  logic [15:0]         in_data,
  input  logic [ADDR_W-1:0]   in_offset,
  input  logic [SIZE_W-1:0]   in_crc_length,
  input  logic [15:0]         in_crc_seed,
  // result channel
  output logic                out_strobe,
  output logic [31:0]         out_read_value,
  output logic                out_value_valid,
  output logic [15:0]         out_crc_out,
  output logic [ADDR_W-1:0]   out_fill_count,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [SIZE_W-1:0]   cfg_wr_data
);

  // Control state
  brbc_state_t         state_r, state_nxt;
  logic [SIZE_W-1:0]   cnt_r;
  logic [ADDR_W-1:0]   wr_idx_r;
  logic [ADDR_W-1:0]   rd_idx_r;
  logic [SIZE_W-1:0]   ring_size_r;
  logic                rd_pend_r;
  logic                out_strobe_r;

  // Latched command
  brbc_cmd_t           cmd_r;
  logic [15:0]         data_r;
  logic [ADDR_W-1:0]   offset_r;
  logic [31:0]         value_r;
  logic [15:0]         crc_r;
  logic                pend_ok_r;

  // Result registers
  logic [31:0]         res_value_r;
  logic                res_valid_r;
  logic [15:0]         res_crc_r;
  logic [ADDR_W-1:0]   res_fill_r;

  // Store and its ports
  logic [7:0]          mem [DEPTH];
  logic [7:0]          rdata_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  logic                accept;
  logic                is_put;
  logic                is_pop;
  logic                run_last;
  logic                sweep_last;

  // Peek address unit
  logic [ADDR_W-1:0]   fill_cur;
  logic                fill_neg;
  logic [SIZE_W:0]     pk_n;
  logic                pk_ok;
  logic [SIZE_W:0]     pk_sum;
  logic [SIZE_W:0]     pk_wrap;
  logic [ADDR_W-1:0]   pk_addr;

  assign accept     = start && (state_r == ST_IDLE);
  assign is_put     = (cmd_r == CMD_PUT8) || (cmd_r == CMD_PUT16);
  assign is_pop     = cmd_r inside {CMD_POP8, CMD_POP16, CMD_POP32};
  assign run_last   = (cnt_r == SIZE_W'(1));
  assign sweep_last = (cnt_r[ADDR_W-1:0] == ADDR_MAX);

  always_comb begin
    fill_cur = ring_fill(wr_idx_r, rd_idx_r, ring_size_r);
    // read index left above a shrunk ring: the count goes below zero and
    // wraps to a huge unsigned value, so every offset counts as filled
    fill_neg = (({1'b0, ring_size_r} + {2'b00, wr_idx_r}) < {2'b00, rd_idx_r});
    if (cmd_r == CMD_CRC) pk_n = {1'b0, cnt_r - SIZE_W'(1)} + {2'b00, offset_r};
    else                  pk_n = {2'b00, offset_r};
    pk_ok   = fill_neg || (pk_n < {2'b00, fill_cur});
    pk_sum  = {2'b00, rd_idx_r} + pk_n;
    pk_wrap = pk_sum - {1'b0, ring_size_r};
    if (pk_sum >= {1'b0, ring_size_r}) pk_addr = pk_wrap[ADDR_W-1:0];
    else                               pk_addr = pk_sum[ADDR_W-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (brbc_cmd_t'(in_cmd) == CMD_CLEAR) state_nxt = ST_CLEAR;
          else if (brbc_cmd_t'(in_cmd) == CMD_CRC && in_crc_length == '0)
            state_nxt = ST_DONE;
          else state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_last) state_nxt = is_put ? ST_DONE : ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_CLEAR: begin
        if (sweep_last) state_nxt = ST_DONE;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Store access and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[ADDR_W-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rd_idx_r;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_RUN: begin
        if (is_put) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_r;
          mem_wdata = (cmd_r == CMD_PUT16 && cnt_r == SIZE_W'(2)) ? data_r[15:8]
                                                                  : data_r[7:0];
        end else if (is_pop) begin
          mem_re = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pk_addr;
        end
      end
      default: begin
      end
    endcase
  end

  // Byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cnt_r        <= '0;
      wr_idx_r     <= '0;
      rd_idx_r     <= '0;
      ring_size_r  <= SIZE_MAX;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_pend_r    <= (state_r == ST_RUN) && mem_re;
      out_strobe_r <= (state_r == ST_DONE);
      if (cfg_wr_en) ring_size_r <= clamp_size(cfg_wr_data);

      case (state_r)
        ST_INIT, ST_CLEAR: begin
          cnt_r <= cnt_r + SIZE_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            case (brbc_cmd_t'(in_cmd))
              CMD_PUT16, CMD_POP16: cnt_r <= SIZE_W'(2);
              CMD_POP32:            cnt_r <= SIZE_W'(4);
              CMD_CRC:              cnt_r <= in_crc_length;
              CMD_CLEAR: begin
                cnt_r    <= '0;
                wr_idx_r <= '0;
                rd_idx_r <= '0;
              end
              default:              cnt_r <= SIZE_W'(1);
            endcase
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r - SIZE_W'(1);
          if (is_put) wr_idx_r <= ring_adv(wr_idx_r, ring_size_r);
          if (is_pop) rd_idx_r <= ring_adv(rd_idx_r, ring_size_r);
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= brbc_cmd_t'(in_cmd);
      data_r   <= in_data;
      offset_r <= in_offset;
      value_r  <= '0;
      crc_r    <= in_crc_seed;
    end

    if (state_r == ST_RUN && !is_put && !is_pop) pend_ok_r <= pk_ok;

    // fold in the byte read in the previous cycle
    if (rd_pend_r) begin
      if (is_pop)                 value_r <= {value_r[23:0], rdata_r};
      else if (cmd_r == CMD_PEEK) value_r <= pend_ok_r ? {24'd0, rdata_r} : 32'd0;
      else                        crc_r   <= crc_step(crc_r, pend_ok_r ? rdata_r
                                                                        : BYTE_INVALID);
    end

    if (state_r == ST_DONE) begin
      res_value_r <= value_r;
      res_valid_r <= is_pop || (cmd_r == CMD_PEEK && pend_ok_r);
      res_crc_r   <= (cmd_r == CMD_CRC) ? crc_r : 16'd0;
      res_fill_r  <= fill_cur;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_read_value  = res_value_r;
  assign out_value_valid = res_valid_r;
  assign out_crc_out     = res_crc_r;
  assign out_fill_count  = res_fill_r;

  // Assertions
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == ST_IDLE))
    else $error("result strobe outside idle");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_strobe_r)
    else $error("finished command gave no result");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_strobe_r && busy)
    else $error("result or idle right after a transfer");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store read and written in one cycle");

  a_pend_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> ($past(state_r) == ST_RUN) && !is_put)
    else $error("read data pending without a read");

endmodule
